@@ hdl/ia8_to_rgba8_hsl_colorize_defines.svh @@
// assertion macros for the colorizer top level rtl
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef IA8_TO_RGBA8_HSL_COLORIZE_DEFINES_SVH
`define IA8_TO_RGBA8_HSL_COLORIZE_DEFINES_SVH

// same-cycle implication, off while reset is low
`define HSLCZ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define HSLCZ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hslcz_pkg.sv @@
// shared types, constants and constant-divide helpers of the colorizer
// no dependencies
package hslcz_pkg;

    // texel indexing and tiling
    localparam int MAX_TEXELS = 1048576;
    localparam int IDX_W      = $clog2(MAX_TEXELS);
    localparam int OFS_W      = IDX_W + 1;
    localparam int TILE_SHIFT = 4;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int HUE_W   = 9;
    localparam int SAT_W   = 7;
    localparam int LIGHT_W = 8;
    localparam int LUM_W   = 16;
    localparam int K_W     = 6;
    localparam int P100_W  = 23;
    localparam int P60_W   = 22;

    // apb register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int STAGES = 8;

    localparam logic [BYTE_W-1:0]  ALPHA_LIMIT = 8'd250;
    localparam logic [LUM_W-1:0]   ONE_Q16     = 16'hFFFF;
    localparam logic [HUE_W-1:0]   HUE_FULL    = 9'd360;
    localparam logic [HUE_W-1:0]   HUE_THIRD   = 9'd120;
    localparam logic [HUE_W-1:0]   HUE_2THIRD  = 9'd240;
    localparam logic [HUE_W-1:0]   HUE_SIXTH   = 9'd60;
    localparam logic [HUE_W-1:0]   HUE_HALF    = 9'd180;
    localparam logic [K_W-1:0]     K_FULL      = 6'd60;
    localparam logic [SAT_W-1:0]   PCT_FULL    = 7'd100;
    localparam logic signed [LIGHT_W-1:0] LIGHT_MAX = 8'sd100;
    localparam logic signed [LIGHT_W-1:0] LIGHT_MIN = -8'sd100;

    // ceiling reciprocals, exact over the value ranges seen here
    localparam int DIV100_SH = 30;
    localparam logic [23:0] DIV100_MUL = 24'd10737419;
    localparam int DIV60_SH = 28;
    localparam logic [22:0] DIV60_MUL = 23'd4473925;
    localparam int DIV257_SH = 24;
    localparam logic [15:0] DIV257_MUL = 16'd65281;

    typedef enum logic [1:0] {
        REG_HUE   = 2'd0,
        REG_SAT   = 2'd1,
        REG_LIGHT = 2'd2
    } t_reg_idx;

    // working settings derived from the register file
    typedef struct packed {
        logic [SAT_W-1:0] sat;   // clamped saturation, 0..100
        logic [SAT_W-1:0] keep;  // 100 - |lightness|
        logic [SAT_W-1:0] lift;  // positive lightness, else zero
        logic [K_W-1:0]   k_r;   // ramp weights in sixtieths
        logic [K_W-1:0]   k_g;
        logic [K_W-1:0]   k_b;
    } t_cfg;

    typedef struct packed {
        logic              bypass;
        logic [BYTE_W-1:0] inten;
        logic [BYTE_W-1:0] alpha;
        logic [OFS_W-1:0]  offset;
    } t_side;

    function automatic logic [LUM_W-1:0] div100(input logic [P100_W-1:0] x);
        logic [P100_W+24-1:0] p;
        p = (P100_W+24)'(x) * (P100_W+24)'(DIV100_MUL);
        return p[DIV100_SH+LUM_W-1:DIV100_SH];
    endfunction

    function automatic logic [LUM_W-1:0] div60(input logic [P60_W-1:0] x);
        logic [P60_W+23-1:0] p;
        p = (P60_W+23)'(x) * (P60_W+23)'(DIV60_MUL);
        return p[DIV60_SH+LUM_W-1:DIV60_SH];
    endfunction

    function automatic logic [BYTE_W-1:0] to_byte(input logic [LUM_W-1:0] v);
        logic [LUM_W+16-1:0] p;
        p = (LUM_W+16)'(v) * (LUM_W+16)'(DIV257_MUL);
        return p[DIV257_SH+BYTE_W-1:DIV257_SH];
    endfunction

endpackage

@@ hdl/hslcz_regs.sv @@
// apb register file for hue, saturation and lightness, plus clamped working settings
// depends on hslcz_pkg
module hslcz_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hslcz_pkg::PADDR_W-1:0]  paddr,
    input  logic [hslcz_pkg::PDATA_W-1:0]  pwdata,
    output logic [hslcz_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output hslcz_pkg::t_cfg                o_cfg
);
    import hslcz_pkg::*;

    logic [HUE_W-1:0]          r_hue;
    logic [SAT_W-1:0]          r_sat;
    logic signed [LIGHT_W-1:0] r_light;

    t_reg_idx                  w_idx;
    logic                      w_wr;
    logic                      w_wr_hue;
    logic                      w_wr_sat;
    logic                      w_wr_light;
    logic [HUE_W-1:0]          w_hue;
    logic [HUE_W-1:0]          w_ang_r;
    logic [HUE_W-1:0]          w_ang_b;
    logic signed [LIGHT_W-1:0] w_light;
    logic signed [LIGHT_W-1:0] w_keep;

    function automatic logic [K_W-1:0] ramp_k(input logic [HUE_W-1:0] x);
        logic [HUE_W-1:0] t;
        t = HUE_2THIRD - x;
        if (x < HUE_SIXTH) begin
            return x[K_W-1:0];
        end else if (x < HUE_HALF) begin
            return K_FULL;
        end else if (x < HUE_2THIRD) begin
            return t[K_W-1:0];
        end
        return '0;
    endfunction

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        w_wr_hue   = 1'b0;
        w_wr_sat   = 1'b0;
        w_wr_light = 1'b0;
        prdata     = '0;
        unique case (w_idx)
            REG_HUE: begin
                w_wr_hue = w_wr;
                prdata   = PDATA_W'(r_hue);
            end
            REG_SAT: begin
                w_wr_sat = w_wr;
                prdata   = PDATA_W'(r_sat);
            end
            REG_LIGHT: begin
                w_wr_light = w_wr;
                prdata     = PDATA_W'(signed'(r_light));
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue   <= '0;
            r_sat   <= '0;
            r_light <= '0;
        end else begin
            if (w_wr_hue) begin
                r_hue <= pwdata[HUE_W-1:0];
            end
            if (w_wr_sat) begin
                r_sat <= pwdata[SAT_W-1:0];
            end
            if (w_wr_light) begin
                r_light <= signed'(pwdata[LIGHT_W-1:0]);
            end
        end
    end

    // hue wraps once, the others saturate
    always_comb begin
        w_hue   = (r_hue > HUE_FULL) ? (r_hue - HUE_FULL) : r_hue;
        w_ang_r = (w_hue > HUE_2THIRD) ? (w_hue - HUE_2THIRD) : (w_hue + HUE_THIRD);
        w_ang_b = (w_hue >= HUE_THIRD) ? (w_hue - HUE_THIRD) : (w_hue + HUE_2THIRD);
        if (r_light > LIGHT_MAX) begin
            w_light = LIGHT_MAX;
        end else if (r_light < LIGHT_MIN) begin
            w_light = LIGHT_MIN;
        end else begin
            w_light = r_light;
        end
        w_keep = (w_light > 0) ? (LIGHT_MAX - w_light) : (LIGHT_MAX + w_light);

        o_cfg.sat  = (r_sat > PCT_FULL) ? PCT_FULL : r_sat;
        o_cfg.keep = w_keep[SAT_W-1:0];
        o_cfg.lift = (w_light > 0) ? w_light[SAT_W-1:0] : '0;
        o_cfg.k_r  = ramp_k(w_ang_r);
        o_cfg.k_g  = ramp_k(w_hue);
        o_cfg.k_b  = ramp_k(w_ang_b);
    end

endmodule

@@ hdl/ia8_to_rgba8_hsl_colorize.sv @@
// ia8 to rgba8 hsl colorizer top level; uses hslcz_pkg, hslcz_regs and the defines header
// throughput: one transaction per cycle while the output is not stalled
// eight register stages lie between input acceptance and o_valid
// a stalled output only holds the stages behind it that are full; bubbles still fill
// reset (synchronous, active low) clears all stage valid bits and the three registers
// the pipeline holds no state between texels, so no clearing pass is needed
`include "ia8_to_rgba8_hsl_colorize_defines.svh"

module ia8_to_rgba8_hsl_colorize (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // texel in
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [hslcz_pkg::BYTE_W-1:0]   i_intensity,
    input  logic [hslcz_pkg::BYTE_W-1:0]   i_alpha_in,
    input  logic [hslcz_pkg::IDX_W-1:0]    i_texel_index,
    // texel out
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [hslcz_pkg::WORD_W-1:0]   o_alpha_red_word,
    output logic [hslcz_pkg::WORD_W-1:0]   o_green_blue_word,
    output logic [hslcz_pkg::OFS_W-1:0]    o_out_offset,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hslcz_pkg::PADDR_W-1:0]  paddr,
    input  logic [hslcz_pkg::PDATA_W-1:0]  pwdata,
    output logic [hslcz_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import hslcz_pkg::*;

    t_cfg w_cfg;

    hslcz_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ------------------------------------------------------------------
    // flow control: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_adv;
    t_side             r_side [STAGES];
    t_side             n_side;

    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int i = STAGES - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (w_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // pass-through fields: bypass flag, raw bytes and the tiled offset
    // offset = tile * 32 + position, i.e. a zero bit slipped in above the position
    always_comb begin
        n_side.bypass = (i_alpha_in < ALPHA_LIMIT);
        n_side.inten  = i_intensity;
        n_side.alpha  = i_alpha_in;
        n_side.offset = {i_texel_index[IDX_W-1:TILE_SHIFT], 1'b0,
                         i_texel_index[TILE_SHIFT-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_side[0] <= n_side;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (w_adv[i]) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: lightness numerator, lum * keep + 65535 * lift
    // lum = intensity * 257 is the byte written twice
    // ------------------------------------------------------------------
    logic [LUM_W-1:0]  w_lum0;
    logic [P100_W-1:0] n_p;
    logic [P100_W-1:0] r1_p;

    assign w_lum0 = {i_intensity, i_intensity};
    assign n_p    = P100_W'(w_lum0) * P100_W'(w_cfg.keep)
                  + P100_W'({w_cfg.lift, 16'h0000}) - P100_W'(w_cfg.lift);

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_p <= n_p;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: adjusted luminance = numerator / 100
    // ------------------------------------------------------------------
    logic [LUM_W-1:0] n_lum;
    logic [LUM_W-1:0] r2_lum;

    assign n_lum = div100(r1_p);

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_lum <= n_lum;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: m2 numerator; dark half scales lum by (100 + s),
    // bright half scales the headroom (65535 - lum) by s
    // ------------------------------------------------------------------
    logic              n_hi;
    logic [LUM_W-1:0]  w_ma;
    logic [BYTE_W-1:0] w_mb;
    logic [P100_W-1:0] n_n;
    logic              r3_hi;
    logic [LUM_W-1:0]  r3_lum;
    logic [P100_W-1:0] r3_n;

    always_comb begin
        n_hi = r2_lum[LUM_W-1];
        w_ma = n_hi ? ~r2_lum : r2_lum;
        w_mb = n_hi ? BYTE_W'(w_cfg.sat) : (BYTE_W'(PCT_FULL) + BYTE_W'(w_cfg.sat));
        n_n  = P100_W'(w_ma) * P100_W'(w_mb);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r3_hi  <= n_hi;
            r3_lum <= r2_lum;
            r3_n   <= n_n;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: m2 = quotient (+ lum in the bright half), clamped to one
    // ------------------------------------------------------------------
    logic [LUM_W-1:0] w_q;
    logic [LUM_W:0]   w_m2x;
    logic [LUM_W-1:0] n_m2;
    logic [LUM_W-1:0] r4_m2;
    logic [LUM_W-1:0] r4_lum;

    always_comb begin
        w_q   = div100(r3_n);
        w_m2x = r3_hi ? ({1'b0, r3_lum} + (LUM_W+1)'(w_q)) : (LUM_W+1)'(w_q);
        n_m2  = w_m2x[LUM_W] ? ONE_Q16 : w_m2x[LUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r4_m2  <= n_m2;
            r4_lum <= r3_lum;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: m1 = 2 * lum - m2, kept within 0..m2; ramp span d = m2 - m1
    // ------------------------------------------------------------------
    logic signed [LUM_W+1:0] w_m1s;
    logic signed [LUM_W+1:0] w_m2s;
    logic [LUM_W-1:0]        n_m1;
    logic [LUM_W-1:0]        n_d;
    logic [LUM_W-1:0]        r5_m1;
    logic [LUM_W-1:0]        r5_d;

    always_comb begin
        w_m2s = $signed({2'b00, r4_m2});
        w_m1s = $signed({1'b0, r4_lum, 1'b0}) - w_m2s;
        if (w_m1s < 0) begin
            n_m1 = '0;
        end else if (w_m1s > w_m2s) begin
            n_m1 = r4_m2;
        end else begin
            n_m1 = w_m1s[LUM_W-1:0];
        end
        n_d = r4_m2 - n_m1;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r5_m1 <= n_m1;
            r5_d  <= n_d;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: span times ramp weight (0..60) for each channel
    // the weight folds the four hue segments into one formula
    // ------------------------------------------------------------------
    logic [P60_W-1:0] n_pr;
    logic [P60_W-1:0] n_pg;
    logic [P60_W-1:0] n_pb;
    logic [P60_W-1:0] r6_pr;
    logic [P60_W-1:0] r6_pg;
    logic [P60_W-1:0] r6_pb;
    logic [LUM_W-1:0] r6_m1;

    assign n_pr = P60_W'(r5_d) * P60_W'(w_cfg.k_r);
    assign n_pg = P60_W'(r5_d) * P60_W'(w_cfg.k_g);
    assign n_pb = P60_W'(r5_d) * P60_W'(w_cfg.k_b);

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r6_pr <= n_pr;
            r6_pg <= n_pg;
            r6_pb <= n_pb;
            r6_m1 <= r5_m1;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: channel fraction = m1 + product / 60
    // ------------------------------------------------------------------
    logic [LUM_W-1:0] n_vr;
    logic [LUM_W-1:0] n_vg;
    logic [LUM_W-1:0] n_vb;
    logic [LUM_W-1:0] r7_vr;
    logic [LUM_W-1:0] r7_vg;
    logic [LUM_W-1:0] r7_vb;

    assign n_vr = r6_m1 + div60(r6_pr);
    assign n_vg = r6_m1 + div60(r6_pg);
    assign n_vb = r6_m1 + div60(r6_pb);

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r7_vr <= n_vr;
            r7_vg <= n_vg;
            r7_vb <= n_vb;
        end
    end

    // ------------------------------------------------------------------
    // stage 8 (output register): fractions to bytes, grey for low alpha
    // zero saturation needs no special path, m1 = m2 = lum there
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] w_r;
    logic [BYTE_W-1:0] w_g;
    logic [BYTE_W-1:0] w_b;
    logic [WORD_W-1:0] n_ar;
    logic [WORD_W-1:0] n_gb;
    logic [WORD_W-1:0] r8_ar;
    logic [WORD_W-1:0] r8_gb;

    always_comb begin
        w_r  = r_side[STAGES-2].bypass ? r_side[STAGES-2].inten : to_byte(r7_vr);
        w_g  = r_side[STAGES-2].bypass ? r_side[STAGES-2].inten : to_byte(r7_vg);
        w_b  = r_side[STAGES-2].bypass ? r_side[STAGES-2].inten : to_byte(r7_vb);
        n_ar = {r_side[STAGES-2].alpha, w_r};
        n_gb = {w_g, w_b};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r8_ar <= n_ar;
            r8_gb <= n_gb;
        end
    end

    assign o_alpha_red_word  = r8_ar;
    assign o_green_blue_word = r8_gb;
    assign o_out_offset      = r_side[STAGES-1].offset;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `HSLCZ_ASSERT_NOW(a_stall_only_when_full, o_stall, ((&r_vld) && i_stall), "input stalled with room in the pipeline")
    `HSLCZ_ASSERT_NOW(a_low_alpha_grey, (o_valid && (o_alpha_red_word[15:8] < ALPHA_LIMIT)), ((o_alpha_red_word[7:0] == o_green_blue_word[15:8]) && (o_green_blue_word[15:8] == o_green_blue_word[7:0])), "low alpha texel is not grey")
    `HSLCZ_ASSERT_NOW(a_zero_sat_grey, (o_valid && (w_cfg.sat == '0)), ((o_alpha_red_word[7:0] == o_green_blue_word[15:8]) && (o_green_blue_word[15:8] == o_green_blue_word[7:0])), "zero saturation texel is not grey")
    `HSLCZ_ASSERT_NEXT(a_pipe_keeps_flowing, (o_valid && !i_stall && r_vld[STAGES-2]), o_valid, "texel lost between last two stages")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the ia8 to rgba8 hsl colorizer
// depends on hslcz_pkg and the ia8_to_rgba8_hsl_colorize rtl; no other files
module tb;

    import hslcz_pkg::*;

    // one texel as offered to the block
    typedef struct packed {
        logic [hslcz_pkg::BYTE_W-1:0] inten;
        logic [hslcz_pkg::BYTE_W-1:0] alpha;
        logic [hslcz_pkg::IDX_W-1:0]  index;
    } t_texel_in;

    // one rgba8 texel as the block hands it back
    typedef struct packed {
        logic [hslcz_pkg::WORD_W-1:0] alpha_red;
        logic [hslcz_pkg::WORD_W-1:0] green_blue;
        logic [hslcz_pkg::OFS_W-1:0]  offset;
    } t_texel_out;

    localparam int RANDOM_SETTINGS  = 16;
    localparam int TEXELS_PER_SET   = 100;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int MAX_IDLE         = 14;
    localparam int DRAIN_CYCLES     = 20;

    // clock, reset and every block input start at a known value
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                           i_valid       = 1'b0;
    logic                           o_stall;
    logic [hslcz_pkg::BYTE_W-1:0]   i_intensity   = '0;
    logic [hslcz_pkg::BYTE_W-1:0]   i_alpha_in    = '0;
    logic [hslcz_pkg::IDX_W-1:0]    i_texel_index = '0;
    logic                           o_valid;
    logic                           i_stall       = 1'b0;
    logic [hslcz_pkg::WORD_W-1:0]   o_alpha_red_word;
    logic [hslcz_pkg::WORD_W-1:0]   o_green_blue_word;
    logic [hslcz_pkg::OFS_W-1:0]    o_out_offset;
    logic                           psel          = 1'b0;
    logic                           penable       = 1'b0;
    logic                           pwrite        = 1'b0;
    logic [hslcz_pkg::PADDR_W-1:0]  paddr         = '0;
    logic [hslcz_pkg::PDATA_W-1:0]  pwdata        = '0;
    logic [hslcz_pkg::PDATA_W-1:0]  prdata;
    logic                           pready;

    always #1 i_clk = ~i_clk;

    ia8_to_rgba8_hsl_colorize DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_intensity       (i_intensity),
        .i_alpha_in        (i_alpha_in),
        .i_texel_index     (i_texel_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_alpha_red_word  (o_alpha_red_word),
        .o_green_blue_word (o_green_blue_word),
        .o_out_offset      (o_out_offset),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // shadow copy of the color registers, reset values are all zero
    logic [hslcz_pkg::HUE_W-1:0]          shadow_hue   = '0;
    logic [hslcz_pkg::SAT_W-1:0]          shadow_sat   = '0;
    logic signed [hslcz_pkg::LIGHT_W-1:0] shadow_light = '0;

    t_texel_in  pending_texels[$];   // waiting to be offered by the driver
    t_texel_out expected_texels[$];  // colorized texels still owed by the block

    // bookkeeping shared between the stimulus and the two clocked processes
    int  texels_queued     = 0;
    int  texels_sent       = 0;
    int  texels_colorized  = 0;
    int  results_checked   = 0;
    int  mismatches        = 0;
    int  settings_applied  = 0;
    int  hold_requests     = 0;
    int  holds_served      = 0;
    bit  sender_idles      = 1'b0;
    bit  receiver_idles    = 1'b0;

    // level of one color channel on the hue circle, angle in degrees
    function automatic int unsigned hue_ramp(input int unsigned lo, input int unsigned hi,
                                             input int angle);
        int unsigned x;
        if (angle > 360) begin
            angle -= 360;
        end else if (angle < 0) begin
            angle += 360;
        end
        x = angle;
        if (x < 60)
            return lo + ((hi - lo) * x) / 60;
        if (x < 180)
            return hi;
        if (x < 240)
            return lo + ((hi - lo) * (240 - x)) / 60;
        return lo;
    endfunction

    // q0.16 fraction down to an 8-bit channel
    function automatic logic [7:0] q16_to_byte(input int unsigned v);
        return 8'(v / 257);
    endfunction

    // expected rgba8 texel and tiled offset for one ia8 texel under the shadow registers
    function automatic t_texel_out colorize_texel(input t_texel_in t);
        t_texel_out  res;
        int unsigned hue, sat, lum, m1, m2, idx;
        int          light, m1s;
        logic [7:0]  red, green, blue;
        if (t.alpha < hslcz_pkg::ALPHA_LIMIT) begin
            // translucent texels stay grey
            red   = t.inten;
            green = t.inten;
            blue  = t.inten;
        end else begin
            hue   = (shadow_hue > 360) ? 32'(shadow_hue) - 360 : 32'(shadow_hue);
            sat   = (shadow_sat > 100) ? 100 : 32'(shadow_sat);
            light = int'(shadow_light);
            if (light > 100)
                light = 100;
            if (light < -100)
                light = -100;
            lum = int'(t.inten) * 257;
            if (light > 0) begin
                lum = (lum * (100 - light) + 65535 * light) / 100;
            end else if (light < 0) begin
                lum = (lum * (100 + light)) / 100;
            end
            if (sat == 0) begin
                red   = q16_to_byte(lum);
                green = red;
                blue  = red;
            end else begin
                if (2 * lum <= 65535) begin
                    m2 = (lum * (100 + sat)) / 100;
                end else begin
                    m2 = lum + (sat * (65535 - lum)) / 100;
                end
                if (m2 > 65535)
                    m2 = 65535;
                m1s = int'(2 * lum) - int'(m2);
                if (m1s < 0)
                    m1s = 0;
                if (m1s > int'(m2))
                    m1s = m2;
                m1    = m1s;
                red   = q16_to_byte(hue_ramp(m1, m2, int'(hue) + 120));
                green = q16_to_byte(hue_ramp(m1, m2, int'(hue)));
                blue  = q16_to_byte(hue_ramp(m1, m2, int'(hue) - 120));
            end
        end
        idx            = 32'(t.index);
        res.alpha_red  = {t.alpha, red};
        res.green_blue = {green, blue};
        res.offset     = hslcz_pkg::OFS_W'((idx >> 4) * 32 + (idx & 15));
        return res;
    endfunction

    // driver: offers queued texels, draws an idle gap for each one
    t_texel_in offered;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            // the transaction being offered went through
            if (i_valid) begin
                expected_texels.push_back(colorize_texel(offered));
                texels_sent++;
                if (offered.alpha >= hslcz_pkg::ALPHA_LIMIT)
                    texels_colorized++;
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_texels.size() > 0) begin
                offered       = pending_texels.pop_front();
                i_intensity   <= offered.inten;
                i_alpha_in    <= offered.alpha;
                i_texel_index <= offered.index;
                i_valid       <= 1'b1;
                gap_left      = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction, drives the receiver stall
    t_texel_out want;
    bit         took;
    int         stall_left = 0;
    int         hold_left  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            took = o_valid && !i_stall;
            if (took) begin
                if (expected_texels.size() == 0) begin
                    $error("result with no texel outstanding, offset %h", o_out_offset);
                    mismatches++;
                end else begin
                    want = expected_texels.pop_front();
                    if (o_alpha_red_word !== want.alpha_red) begin
                        $error("alpha_red_word: expected %h, got %h",
                               want.alpha_red, o_alpha_red_word);
                        mismatches++;
                    end
                    if (o_green_blue_word !== want.green_blue) begin
                        $error("green_blue_word: expected %h, got %h",
                               want.green_blue, o_green_blue_word);
                        mismatches++;
                    end
                    if (o_out_offset !== want.offset) begin
                        $error("out_offset: expected %h, got %h", want.offset, o_out_offset);
                        mismatches++;
                    end
                    results_checked++;
                end
            end
            // a long hold-off takes priority over the per-result stalls
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else begin
                if (took)
                    stall_left = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // every queued texel has come back, so the pipeline is empty
    task automatic wait_drained();
        @(posedge i_clk);
        while (results_checked != texels_queued)
            @(posedge i_clk);
    endtask

    // apb write, setup phase then access phase, then back to idle; shadow register follows at the write edge
    task automatic cfg_write(input t_reg_idx which, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (which)
            REG_HUE:   shadow_hue   = value[hslcz_pkg::HUE_W-1:0];
            REG_SAT:   shadow_sat   = value[hslcz_pkg::SAT_W-1:0];
            REG_LIGHT: shadow_light = value[hslcz_pkg::LIGHT_W-1:0];
            default:   ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // new color setting, only once the block has gone quiet
    task automatic apply_setting(input int hue, input int sat, input int light);
        wait_drained();
        cfg_write(REG_HUE, 32'(hue) & 32'h1FF);
        cfg_write(REG_SAT, 32'(sat) & 32'h7F);
        cfg_write(REG_LIGHT, 32'(light) & 32'hFF);
        settings_applied++;
    endtask

    task automatic queue_texel(input int inten, input int alpha, input int index);
        t_texel_in t;
        t.inten = BYTE_W'(inten);
        t.alpha = BYTE_W'(alpha);
        t.index = IDX_W'(index);
        pending_texels.push_back(t);
        texels_queued++;
    endtask

    // mostly opaque texels so the color path gets the bulk of the traffic
    task automatic queue_random_texels(input int count);
        int alpha;
        repeat (count) begin
            alpha = ($urandom_range(0, 3) != 0) ? $urandom_range(250, 255)
                                                : $urandom_range(0, 255);
            queue_texel($urandom_range(0, 255), alpha, $urandom_range(0, 20'hFFFFF));
        end
    endtask

    initial begin
        int hue, sat, light;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values first, both sides idle-free
        queue_texel(0, 255, 0);
        queue_texel(255, 255, 15);
        queue_texel(128, 250, 16);
        queue_texel(77, 249, 20'hFFFFF);
        queue_texel(255, 0, 20'h8000F);

        // full saturation, red hue, no lightness shift
        apply_setting(0, 100, 0);
        queue_texel(255, 255, 1);
        queue_texel(0, 255, 2);
        queue_texel(128, 255, 3);
        queue_texel(64, 250, 4);

        // hue at the top of the circle, lightened all the way to white
        apply_setting(360, 100, 100);
        queue_texel(0, 255, 17);
        queue_texel(200, 255, 31);
        queue_texel(255, 249, 32);

        // hue and saturation past their ranges, lightness below -100
        apply_setting(511, 127, -128);
        queue_texel(255, 255, 20'h7FFF0);
        queue_texel(100, 255, 20'hAAAAA);
        queue_texel(0, 250, 20'h55555);

        // darkened to black, mid saturation
        apply_setting(120, 50, -100);
        queue_texel(255, 255, 48);
        queue_texel(128, 255, 63);

        // lightness above 100, blue hue
        apply_setting(240, 100, 127);
        queue_texel(10, 255, 64);
        queue_texel(128, 255, 65);

        // just past each limit
        apply_setting(361, 101, -101);
        queue_texel(200, 255, 20'hFFFF0);
        queue_texel(50, 255, 20'h0000F);

        // random settings, idling pattern cycles through the four combinations
        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            hue   = ($urandom_range(0, 3) == 0) ? $urandom_range(361, 511)
                                                : $urandom_range(0, 360);
            sat   = ($urandom_range(0, 5) == 0) ? 0 :
                    ($urandom_range(0, 3) == 0) ? $urandom_range(101, 127)
                                                : $urandom_range(1, 100);
            light = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 200)) - 100 :
                    ($urandom_range(0, 1) != 0) ? $urandom_range(101, 127)
                                                : -int'($urandom_range(101, 128));
            apply_setting(hue, sat, light);
            sender_idles   = s[0];
            receiver_idles = s[1];
            if (s == 3) begin
                // back-to-back texels against a long receiver hold-off fill the pipe
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
                hold_requests++;
            end
            if (s == 6) begin
                // sender stops halfway until every result is back
                queue_random_texels(TEXELS_PER_SET / 2);
                wait_drained();
                queue_random_texels(TEXELS_PER_SET / 2);
            end else begin
                queue_random_texels(TEXELS_PER_SET);
            end
        end

        wait_drained();
        // catch any stray result past the pipeline latency
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_texels.size() != 0) begin
            $error("%0d colorized texels never came back", expected_texels.size());
            mismatches++;
        end

        $display("checked %0d texels (%0d colorized, rest grey) over %0d register settings",
                 results_checked, texels_colorized, settings_applied);
        $display("%0d field mismatches, %0d long receiver hold-offs", mismatches, holds_served);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/hslcz_pkg.sv
hdl/hslcz_regs.sv
hdl/ia8_to_rgba8_hsl_colorize.sv
verif/tb.sv
